// ----- rtl/cabe_pkg.sv -----
package cabe_pkg;

    localparam int COORD_W = 8;
    localparam int CFG_W   = 9;
    localparam int IDX_W   = 18;
    localparam int PIX_W   = 32;
    localparam int ADDR_W  = 16;
    localparam int CIDX_W  = 3;

    localparam logic [1:0] MODE_BLIT = 2'd0;
    localparam logic [1:0] MODE_PLOT = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_FILL = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_DEST_WIDTH    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_DEST_HEIGHT   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_PLACE_X       = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_PLACE_Y       = 3'd5;

    localparam logic [CFG_W-1:0] SIZE_RESET  = 9'd256;
    localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [CFG_W-1:0] dest_width;
        logic [CFG_W-1:0] dest_height;
        logic [CFG_W-1:0] source_width;
        logic [CFG_W-1:0] source_height;
        logic [CFG_W-1:0] place_x;
        logic [CFG_W-1:0] place_y;
    } cfg_t;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } clip_t;

endpackage

// ----- rtl/cabe_ram.sv -----
module cabe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/cabe_clip.sv -----
module cabe_clip
    import cabe_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic [1:0]         mode,
    input  logic [COORD_W-1:0] col,
    input  logic [COORD_W-1:0] row,
    input  cfg_t               cfg,
    output clip_t              clip,
    output logic [IDX_W-1:0]   area
);

    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic signed [CFG_W:0] x;
    logic signed [CFG_W:0] y;
    logic src_ok;
    logic x_ok;
    logic y_ok;

    assign w = (int'(cfg.dest_width) < MAX_WIDTH) ? cfg.dest_width : CFG_W'(MAX_WIDTH);
    assign h = (int'(cfg.dest_height) < MAX_HEIGHT) ? cfg.dest_height : CFG_W'(MAX_HEIGHT);

    always_comb
    begin
        if (mode == MODE_BLIT)
        begin
            x = $signed({cfg.place_x[CFG_W-1], cfg.place_x}) + $signed({2'b00, col});
            y = $signed({cfg.place_y[CFG_W-1], cfg.place_y}) + $signed({2'b00, row});
            src_ok = ({1'b0, col} < cfg.source_width) && ({1'b0, row} < cfg.source_height);
        end
        else
        begin
            x = $signed({2'b00, col});
            y = $signed({2'b00, row});
            src_ok = 1'b1;
        end
    end

    assign x_ok = !x[CFG_W] && (x[CFG_W-1:0] < w);
    assign y_ok = !y[CFG_W] && (y[CFG_W-1:0] < h);

    assign clip.ok  = src_ok && x_ok && y_ok;
    assign clip.idx = IDX_W'(x[CFG_W-1:0]) + IDX_W'(y[CFG_W-1:0]) * IDX_W'(w);
    assign area     = IDX_W'(w) * IDX_W'(h);

endmodule

// ----- rtl/cabe_blend.sv -----
module cabe_blend
    import cabe_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [PIX_W-1:0] cur,
    input  logic [PIX_W-1:0] src,
    output logic [PIX_W-1:0] result
);

    logic [7:0]  alpha;
    logic [7:0]  inv_alpha;
    logic [15:0] pcur_reg [3];
    logic [15:0] psrc_reg [3];
    logic [7:0]  chan [3];

    assign alpha     = src[7:0];
    assign inv_alpha = ALPHA_OPAQUE - alpha;

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        logic [15:0] sum;
        logic [16:0] q;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pcur_reg[c] <= cur[31-8*c -: 8] * inv_alpha;
                psrc_reg[c] <= src[31-8*c -: 8] * alpha;
            end
        end

        // exact floor(sum / 255) for sum <= 255*255
        assign sum     = pcur_reg[c] + psrc_reg[c];
        assign q       = 17'(sum) + 17'(sum[15:8]) + 17'd1;
        assign chan[c] = q[15:8];
    end

    assign result = {chan[0], chan[1], chan[2], ALPHA_OPAQUE};

endmodule

// ----- rtl/clipped_alpha_blit_engine_core.sv -----
// Pixel engine over an internal RGBA frame store of MAX_WIDTH*MAX_HEIGHT words.
// Each beat on the input channel (blit, plot, read or fill) returns exactly one
// result beat. One item is in flight at a time. Its result passes through clip
// and address, read issue, frame store read and blend multiply, then write-back
// with the result loaded into the output register; write-back waits while an
// earlier result is still held on a stalled output. These steps make up the
// single read-modify-write pass through the frame store. The next item is only
// accepted once the engine is back in idle, and a new item is taken while an
// earlier result still waits on the output. After reset the store is cleared,
// one word a cycle, through all MAX_WIDTH*MAX_HEIGHT words, and in_stall stays
// high until that is done; configuration writes are taken at any time and must
// only be issued while no item is in flight.
module clipped_alpha_blit_engine_core
    import cabe_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic               blend,
    input  logic [COORD_W-1:0] pos_col,
    input  logic [COORD_W-1:0] pos_row,
    input  logic [PIX_W-1:0]   pixel_color,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [PIX_W-1:0]   read_color,
    output logic [ADDR_W-1:0]  pixel_address,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    cfg_t               cfg_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [IDX_W-1:0]   fill_cnt_reg;

    logic [1:0]         mode_reg;
    logic               blend_reg;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [PIX_W-1:0]   color_reg;
    clip_t              clip_reg;
    logic [IDX_W-1:0]   area_reg;
    logic               ok_reg;
    logic [IDX_W-1:0]   addr_reg;

    logic               out_valid_reg;
    logic               status_reg;
    logic [PIX_W-1:0]   read_color_reg;
    logic [ADDR_W-1:0]  pixel_address_reg;

    clip_t              clip;
    logic [IDX_W-1:0]   area;
    logic [IDX_W-1:0]   fill_addr;
    logic [IDX_W-1:0]   fill_inc;
    logic               in_accept;
    logic               slot_free;
    logic               finish;
    logic               item_write;
    logic [PIX_W-1:0]   rdata;
    logic [PIX_W-1:0]   blend_pix;
    logic [PIX_W-1:0]   new_pix;
    logic [PIX_W-1:0]   result;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [PIX_W-1:0]   ram_wdata;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || !out_stall;
    assign finish    = (state_reg == S_DONE) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC: state_next = S_ADDR;
            S_ADDR: state_next = S_READ;
            S_READ: state_next = S_MUL;
            S_MUL:  state_next = S_DONE;
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (state_reg == S_CLEAR)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_width    <= SIZE_RESET;
            cfg_reg.dest_height   <= SIZE_RESET;
            cfg_reg.source_width  <= SIZE_RESET;
            cfg_reg.source_height <= SIZE_RESET;
            cfg_reg.place_x       <= '0;
            cfg_reg.place_y       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEST_WIDTH:    cfg_reg.dest_width    <= cfg_data;
                CFG_DEST_HEIGHT:   cfg_reg.dest_height   <= cfg_data;
                CFG_SOURCE_WIDTH:  cfg_reg.source_width  <= cfg_data;
                CFG_SOURCE_HEIGHT: cfg_reg.source_height <= cfg_data;
                CFG_PLACE_X:       cfg_reg.place_x       <= cfg_data;
                CFG_PLACE_Y:       cfg_reg.place_y       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg  <= mode;
            blend_reg <= blend;
            col_reg   <= pos_col;
            row_reg   <= pos_row;
            color_reg <= pixel_color;
        end
        if (state_reg == S_CALC)
        begin
            clip_reg <= clip;
            area_reg <= area;
        end
    end

    cabe_clip #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_clip (
        .mode (mode_reg),
        .col  (col_reg),
        .row  (row_reg),
        .cfg  (cfg_reg),
        .clip (clip),
        .area (area)
    );

    // fill walk restarts when the surface shrank below the counter
    assign fill_addr = (fill_cnt_reg >= area_reg) ? '0 : fill_cnt_reg;
    assign fill_inc  = fill_addr + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
        end
        else if ((state_reg == S_ADDR) && (mode_reg == MODE_FILL) && (area_reg != '0))
        begin
            fill_cnt_reg <= (fill_inc >= area_reg) ? '0 : fill_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADDR)
        begin
            if (mode_reg == MODE_FILL)
            begin
                ok_reg   <= (area_reg != '0);
                addr_reg <= fill_addr;
            end
            else
            begin
                ok_reg   <= clip_reg.ok;
                addr_reg <= clip_reg.idx;
            end
        end
    end

    cabe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(addr_reg)),
        .rdata (rdata)
    );

    cabe_blend u_blend (
        .clk    (clk),
        .en     (state_reg == S_MUL),
        .cur    (rdata),
        .src    (color_reg),
        .result (blend_pix)
    );

    assign new_pix = (blend_reg && (color_reg[7:0] != ALPHA_OPAQUE)) ? blend_pix : color_reg;

    always_comb
    begin
        item_write = 1'b0;
        result     = '0;
        if (ok_reg)
        begin
            case (mode_reg)
                MODE_READ: result = rdata;
                MODE_FILL:
                begin
                    result     = color_reg;
                    item_write = 1'b1;
                end
                default:
                begin
                    result     = new_pix;
                    item_write = 1'b1;
                end
            endcase
        end
    end

    assign ram_we    = (state_reg == S_CLEAR) || (finish && item_write);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : AW'(addr_reg);
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg        <= !ok_reg;
            read_color_reg    <= result;
            pixel_address_reg <= ok_reg ? addr_reg[ADDR_W-1:0] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign read_color    = read_color_reg;
    assign pixel_address = pixel_address_reg;

endmodule

// ----- rtl/cabe_checker.sv -----
module cabe_checker
    import cabe_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               status,
    input logic [PIX_W-1:0]   read_color,
    input logic [ADDR_W-1:0]  pixel_address
);

    // one item in flight: an accepted beat closes the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after an accepted beat");

    // a fresh result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in flight");

    // dropped beats carry neither colour nor address
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (read_color == '0) && (pixel_address == '0))
        else $error("dropped result carries data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(status)
            && $stable(read_color) && $stable(pixel_address))
        else $error("stalled result changed");

endmodule

bind clipped_alpha_blit_engine_core cabe_checker u_cabe_checker (.*);

// ----- test/tb_clipped_alpha_blit_engine_core.sv -----
`timescale 1ns / 1ps

module tb_clipped_alpha_blit_engine_core;
    import cabe_pkg::*;

    localparam int FRAME_W     = 256;
    localparam int FRAME_H     = 256;
    localparam int QUIET_LIMIT = 4 * FRAME_W * FRAME_H;

    typedef struct packed {
        logic [1:0]  kind;
        logic        blend_on;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [31:0] color;
    } pixel_op_t;

    typedef struct packed {
        logic        status;
        logic [31:0] color;
        logic [15:0] addr;
    } pix_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         mode;
    logic               blend;
    logic [COORD_W-1:0] pos_col;
    logic [COORD_W-1:0] pos_row;
    logic [PIX_W-1:0]   pixel_color;
    logic               out_valid;
    logic               out_stall;
    logic               status;
    logic [PIX_W-1:0]   read_color;
    logic [ADDR_W-1:0]  pixel_address;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    // predictor state
    logic [31:0] frame_copy [0:FRAME_W*FRAME_H-1];
    int          fill_next;
    int          surf_w, surf_h, src_w, src_h, off_x, off_y;

    pix_result_t pending_results [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          long_hold = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;

    clipped_alpha_blit_engine_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .blend         (blend),
        .pos_col       (pos_col),
        .pos_row       (pos_row),
        .pixel_color   (pixel_color),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .read_color    (read_color),
        .pixel_address (pixel_address),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic void model_reset();
        foreach (frame_copy[i])
            frame_copy[i] = '0;
        fill_next = 0;
        surf_w    = 256;
        surf_h    = 256;
        src_w     = 256;
        src_h     = 256;
        off_x     = 0;
        off_y     = 0;
    endfunction

    function automatic void model_write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_DEST_WIDTH:    surf_w = int'(data);
            CFG_DEST_HEIGHT:   surf_h = int'(data);
            CFG_SOURCE_WIDTH:  src_w = int'(data);
            CFG_SOURCE_HEIGHT: src_h = int'(data);
            CFG_PLACE_X:       off_x = int'($signed(data));
            CFG_PLACE_Y:       off_y = int'($signed(data));
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] blend_over(logic [31:0] cur, logic [31:0] src);
        int          a;
        int          v;
        logic [31:0] mixed;
        a          = int'(src[7:0]);
        mixed[7:0] = ALPHA_OPAQUE;
        for (int c = 1; c < 4; c++)
        begin
            v = (int'(cur[c*8 +: 8]) * (255 - a) + int'(src[c*8 +: 8]) * a) / 255;
            mixed[c*8 +: 8] = v[7:0];
        end
        return mixed;
    endfunction

    function automatic pix_result_t predict_pixel_op(pixel_op_t p);
        pix_result_t r;
        int          w, h, area, x, y, idx;
        bit          ok;
        logic [31:0] nc;
        r.status = 1'b1;
        r.color  = '0;
        r.addr   = '0;
        w = (surf_w < FRAME_W) ? surf_w : FRAME_W;
        h = (surf_h < FRAME_H) ? surf_h : FRAME_H;
        if (p.kind == MODE_FILL)
        begin
            area = w * h;
            if (area != 0)
            begin
                if (fill_next >= area)
                    fill_next = 0;
                frame_copy[fill_next] = p.color;
                r.status  = 1'b0;
                r.color   = p.color;
                r.addr    = fill_next[15:0];
                fill_next = (fill_next + 1 >= area) ? 0 : fill_next + 1;
            end
        end
        else
        begin
            x  = int'(p.col);
            y  = int'(p.row);
            ok = 1'b1;
            if (p.kind == MODE_BLIT)
            begin
                if (int'(p.col) >= src_w || int'(p.row) >= src_h)
                    ok = 1'b0;
                x = off_x + int'(p.col);
                y = off_y + int'(p.row);
            end
            if (x < 0 || y < 0 || x >= w || y >= h)
                ok = 1'b0;
            if (ok)
            begin
                idx      = x + y * w;
                r.status = 1'b0;
                r.addr   = idx[15:0];
                if (p.kind == MODE_READ)
                    r.color = frame_copy[idx];
                else
                begin
                    nc = p.color;
                    if (p.blend_on && p.color[7:0] != ALPHA_OPAQUE)
                        nc = blend_over(frame_copy[idx], p.color);
                    frame_copy[idx] = nc;
                    r.color         = nc;
                end
            end
        end
        return r;
    endfunction

    function automatic pixel_op_t random_pixel_op();
        pixel_op_t p;
        int        pick, w, h;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            p.kind = MODE_BLIT;
        else if (pick < 60)
            p.kind = MODE_PLOT;
        else if (pick < 85)
            p.kind = MODE_READ;
        else
            p.kind = MODE_FILL;
        p.blend_on = 1'($urandom_range(0, 1));
        p.color    = $urandom();
        case ($urandom_range(0, 7))
            0, 1: p.color[7:0] = ALPHA_OPAQUE;
            2:    p.color[7:0] = 8'h00;
            default: ;
        endcase
        p.col = 8'($urandom_range(0, 255));
        p.row = 8'($urandom_range(0, 255));
        // mostly aim inside the surface that the position refers to
        if ($urandom_range(0, 9) != 0)
        begin
            if (p.kind == MODE_BLIT)
            begin
                w = src_w;
                h = src_h;
            end
            else
            begin
                w = surf_w;
                h = surf_h;
            end
            if (w > FRAME_W)
                w = FRAME_W;
            if (h > FRAME_H)
                h = FRAME_H;
            if (w > 0)
                p.col = 8'($urandom_range(0, w - 1));
            if (h > 0)
                p.row = 8'($urandom_range(0, h - 1));
        end
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // valid is left high on return; the next call or settle() decides it in the same step
    task automatic send_pixel_op(logic [1:0] kind, logic bl, logic [7:0] col, logic [7:0] row,
                                 logic [31:0] color);
        pixel_op_t p;
        p.kind     = kind;
        p.blend_on = bl;
        p.col      = col;
        p.row      = row;
        p.color    = color;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= kind;
        blend       <= bl;
        pos_col     <= col;
        pos_row     <= row;
        pixel_color <= color;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_pixel_op(p));
    endtask

    task automatic send_random_ops(int count);
        pixel_op_t p;
        for (int i = 0; i < count; i++)
        begin
            p = random_pixel_op();
            send_pixel_op(p.kind, p.blend_on, p.col, p.row, p.color);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_surface(int dw, int dh, int sw, int sh, int px, int py);
        logic [CIDX_W-1:0] regs [6];
        logic [CFG_W-1:0]  vals [6];
        regs = '{CFG_DEST_WIDTH, CFG_DEST_HEIGHT, CFG_SOURCE_WIDTH, CFG_SOURCE_HEIGHT,
                 CFG_PLACE_X, CFG_PLACE_Y};
        vals = '{dw[8:0], dh[8:0], sw[8:0], sh[8:0], px[8:0], py[8:0]};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            model_write_reg(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_modes();
        send_pixel_op(MODE_PLOT, 1'b0, 8'd0, 8'd0, 32'h1122_3380);
        send_pixel_op(MODE_PLOT, 1'b1, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send_pixel_op(MODE_PLOT, 1'b1, 8'd0, 8'd0, 32'h0000_0000);
        send_pixel_op(MODE_PLOT, 1'b1, 8'd0, 8'd0, 32'hFF80_407F);
        send_pixel_op(MODE_READ, 1'b1, 8'd0, 8'd0, 32'hA5A5_5A5A);
        send_pixel_op(MODE_READ, 1'b0, 8'd255, 8'd255, 32'h0000_0000);
        send_pixel_op(MODE_BLIT, 1'b1, 8'd255, 8'd255, 32'hA0B0_C001);
        send_pixel_op(MODE_BLIT, 1'b0, 8'd0, 8'd0, 32'h0102_0304);
        send_pixel_op(MODE_FILL, 1'b0, 8'd17, 8'd3, 32'hDEAD_BEEF);
        send_pixel_op(MODE_READ, 1'b0, 8'd0, 8'd0, 32'h0000_0000);
        send_pixel_op(MODE_FILL, 1'b1, 8'd0, 8'd0, 32'h1234_5610);
        send_pixel_op(MODE_READ, 1'b0, 8'd1, 8'd0, 32'h0000_0000);
        settle();
    endtask

    task automatic test_clipping();
        set_surface(20, 12, 6, 5, -3, 9);
        send_pixel_op(MODE_BLIT, 1'b0, 8'd0, 8'd0, 32'h1111_11FF);
        send_pixel_op(MODE_BLIT, 1'b1, 8'd5, 8'd2, 32'h2222_2240);
        send_pixel_op(MODE_BLIT, 1'b0, 8'd5, 8'd3, 32'h3333_33FF);
        send_pixel_op(MODE_BLIT, 1'b0, 8'd6, 8'd0, 32'h4444_44FF);
        send_pixel_op(MODE_PLOT, 1'b0, 8'd19, 8'd11, 32'h5555_55FF);
        send_pixel_op(MODE_PLOT, 1'b0, 8'd20, 8'd0, 32'h6666_66FF);
        send_pixel_op(MODE_PLOT, 1'b0, 8'd0, 8'd12, 32'h7777_77FF);
        send_pixel_op(MODE_READ, 1'b0, 8'd19, 8'd11, 32'h0000_0000);
        send_pixel_op(MODE_READ, 1'b0, 8'd255, 8'd255, 32'h0000_0000);
        settle();
    endtask

    task automatic test_size_extremes();
        // zero width drops everything, fill too
        set_surface(0, 256, 256, 256, 0, 0);
        send_pixel_op(MODE_FILL, 1'b0, 8'd0, 8'd0, 32'hCAFE_F00D);
        send_pixel_op(MODE_PLOT, 1'b0, 8'd0, 8'd0, 32'hCAFE_F00D);
        settle();
        // oversize registers clamp to the frame
        set_surface(511, 300, 511, 300, 0, 0);
        send_pixel_op(MODE_PLOT, 1'b1, 8'd255, 8'd255, 32'h8040_2080);
        send_pixel_op(MODE_BLIT, 1'b1, 8'd255, 8'd255, 32'h0F0F_0FC0);
        send_pixel_op(MODE_READ, 1'b0, 8'd255, 8'd255, 32'h0000_0000);
        settle();
    endtask

    task automatic test_random_surfaces();
        set_surface(256, 256, 256, 256, 0, 0);
        send_random_ops(90);
        settle();
        set_surface(4, 3, 4, 3, 0, 0);
        send_random_ops(60);
        settle();
        set_surface(1, 1, 1, 1, 0, 0);
        send_random_ops(30);
        settle();
        set_surface(256, 256, 256, 256, -256, 255);
        send_random_ops(30);
        settle();
        set_surface(511, 511, 300, 400, 255, -256);
        send_random_ops(30);
        settle();
        for (int i = 0; i < 4; i++)
        begin
            set_surface($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(1, 32),
                        $urandom_range(1, 32), int'($urandom_range(0, 32)) - 16,
                        int'($urandom_range(0, 32)) - 16);
            send_random_ops(80);
            settle();
        end
    endtask

    task automatic test_output_hold();
        set_surface(12, 10, 14, 9, -2, 1);
        src_idle_on = 1'b0;
        long_hold <= 400;
        send_random_ops(30);
        settle();
        src_idle_on = 1'b1;
    endtask

    task automatic test_no_idle();
        src_idle_on = 1'b0;
        sink_idle_on <= 1'b0;
        set_surface(16, 16, 16, 16, 3, -3);
        send_random_ops(100);
        settle();
    endtask

    // receiver side: random stall bursts plus one long hold on request
    initial
    begin : sink_side
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold != 0)
            begin
                n = long_hold;
                long_hold = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        pix_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", read_color, 32'h0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (read_color !== want.color)
                    report_mismatch("read_color", read_color, want.color);
                if (pixel_address !== want.addr)
                    report_mismatch("pixel_address", 32'(pixel_address), 32'(want.addr));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $realtime, quiet_cycles);
                $display("tb_clipped_alpha_blit_engine_core failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= MODE_BLIT;
        blend       <= 1'b0;
        pos_col     <= '0;
        pos_row     <= '0;
        pixel_color <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_DEST_WIDTH;
        cfg_data    <= '0;
        model_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_modes();
        test_clipping();
        test_size_extremes();
        test_random_surfaces();
        test_output_hold();
        test_no_idle();

        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("tb_clipped_alpha_blit_engine_core passed");
        else
            $display("tb_clipped_alpha_blit_engine_core failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cabe_pkg.sv
rtl/cabe_ram.sv
rtl/cabe_clip.sv
rtl/cabe_blend.sv
rtl/clipped_alpha_blit_engine_core.sv
rtl/cabe_checker.sv
test/tb_clipped_alpha_blit_engine_core.sv
